>>> design/sampled_dense_dot_products_csc_macros.svh
// Assertion macros for the sampled dense dot products block.
// Used by the top level; relies on signals named clk and rst in scope.
`ifndef SAMPLED_DENSE_DOT_PRODUCTS_CSC_MACROS_SVH
`define SAMPLED_DENSE_DOT_PRODUCTS_CSC_MACROS_SVH
`ifndef SYNTH
// Condition holds at every clock edge outside reset.
`define SDDP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sddp: invariant violated");
// Antecedent at one edge implies the consequent at the next edge.
`define SDDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sddp: sequence violated");
// Antecedent implies the consequent at the same edge.
`define SDDP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sddp: implication violated");
`else
`define SDDP_ASSERT(lbl, cond)
`define SDDP_ASSERT_NEXT(lbl, ante, cons)
`define SDDP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> design/sddp_pkg.sv
// Shared types and constants for the sampled dense dot products block.
// No dependencies; used by the controller, the datapath and the top level.
package sddp_pkg;

  localparam int LATENT_MAX_DEFAULT  = 64;
  localparam int ROWS_MAX_DEFAULT    = 64;
  localparam int COLS_MAX_DEFAULT    = 32;
  localparam int SAMPLES_MAX_DEFAULT = 4096;

  localparam int CFG_DATA_W = 7;

  localparam logic CFG_LATENT_DIM  = 1'b0;
  localparam logic CFG_NUM_COLUMNS = 1'b1;

  localparam logic [6:0] LATENT_DIM_RESET  = 7'd64;
  localparam logic [5:0] NUM_COLUMNS_RESET = 6'd32;

  localparam logic [1:0] CMD_LOAD_U = 2'd0;
  localparam logic [1:0] CMD_LOAD_V = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_FINISH = 2'd3;

  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_POINTER = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         row_index;
    logic [4:0]         col_index;
    logic [5:0]         latent_index;
    logic signed [15:0] element;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic signed [39:0] dot_value;
    logic [5:0]         row_out;
    logic [5:0]         pointer_index;
    logic [12:0]        pointer_value;
    logic               last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic emit_ptr;
    logic mac_start;
    logic emit_entry;
    logic finish_clear;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic ptr_more;
    logic is_finish;
    logic dot_done;
  } dp_status_t;

endpackage

>>> design/sddp_ctrl.sv
// Controller state machine for the sampled dense dot products block.
// Depends on sddp_pkg for the command codes and the command/status structs.
module sddp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_stall,
  output sddp_pkg::dp_cmd_t   dp_cmd,
  input  sddp_pkg::dp_status_t dp_status
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PTR  = 4'b0010,
    ST_MAC  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          dp_cmd.capture = 1'b1;
          if (in_cmd inside {sddp_pkg::CMD_SAMPLE, sddp_pkg::CMD_FINISH}) begin
            state_next = ST_PTR;
          end
        end
      end
      ST_PTR: begin
        if (dp_status.ptr_more) begin
          dp_cmd.emit_ptr = dp_status.slot_free;
        end else if (dp_status.is_finish) begin
          dp_cmd.finish_clear = 1'b1;
          state_next          = ST_IDLE;
        end else begin
          dp_cmd.mac_start = 1'b1;
          state_next       = ST_MAC;
        end
      end
      ST_MAC: begin
        if (dp_status.dot_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (dp_status.slot_free) begin
          dp_cmd.emit_entry = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/sddp_dp.sv
// Datapath: embedding memories, multiply-accumulate pipeline, column and
// sample counters, configuration registers and the result register. Uses sddp_pkg.
module sddp_dp #(
  parameter int LATENT_MAX  = sddp_pkg::LATENT_MAX_DEFAULT,
  parameter int ROWS_MAX    = sddp_pkg::ROWS_MAX_DEFAULT,
  parameter int COLS_MAX    = sddp_pkg::COLS_MAX_DEFAULT,
  parameter int SAMPLES_MAX = sddp_pkg::SAMPLES_MAX_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sddp_pkg::in_t               in_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sddp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  sddp_pkg::dp_cmd_t           dp_cmd,
  output sddp_pkg::dp_status_t        dp_status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sddp_pkg::out_t              out_data
);

  localparam int U_DEPTH = ROWS_MAX * LATENT_MAX;
  localparam int V_DEPTH = COLS_MAX * LATENT_MAX;
  localparam int UA_W    = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
  localparam int VA_W    = (V_DEPTH > 1) ? $clog2(V_DEPTH) : 1;
  localparam int KW      = $clog2(LATENT_MAX + 1);
  localparam int CW      = $clog2(SAMPLES_MAX + 1);

  logic [15:0] u_mem [U_DEPTH];
  logic [15:0] v_mem [V_DEPTH];

  logic [6:0]          latent_dim;
  logic [5:0]          num_columns;
  logic [5:0]          ncol;
  logic [KW-1:0]       lat_eff;

  logic [1:0]          cmd_q;
  logic [5:0]          row_q;
  logic [4:0]          col_q;

  logic [5:0]          next_column;
  logic [CW-1:0]       sample_count;

  logic [KW-1:0]       k;
  logic [KW-1:0]       k_len;
  logic                running;
  logic                d1;
  logic                d2;
  logic [UA_W-1:0]     u_raddr;
  logic [VA_W-1:0]     v_raddr;
  logic [UA_W-1:0]     u_waddr;
  logic [VA_W-1:0]     v_waddr;
  logic                u_we;
  logic                v_we;
  logic signed [15:0]  u_q;
  logic signed [15:0]  v_q;
  logic signed [31:0]  prod;
  logic signed [39:0]  acc;
  logic                sample_in_range;

  // Configuration registers, clamped to the parameters where used.
  always_ff @(posedge clk) begin
    if (rst) begin
      latent_dim  <= sddp_pkg::LATENT_DIM_RESET;
      num_columns <= sddp_pkg::NUM_COLUMNS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sddp_pkg::CFG_LATENT_DIM:  latent_dim  <= cfg_data;
        sddp_pkg::CFG_NUM_COLUMNS: num_columns <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign ncol    = (32'(num_columns) > COLS_MAX) ? 6'(COLS_MAX) : num_columns;
  assign lat_eff = (32'(latent_dim) > LATENT_MAX) ? KW'(LATENT_MAX) : KW'(latent_dim);

  // Request capture.
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_q <= in_data.cmd;
      row_q <= in_data.row_index;
      col_q <= in_data.col_index;
    end
  end

  // Loads write the memories directly at the accepting edge.
  assign u_we = dp_cmd.capture && (in_data.cmd == sddp_pkg::CMD_LOAD_U)
                && (32'(in_data.row_index) < ROWS_MAX)
                && (32'(in_data.latent_index) < LATENT_MAX);
  assign v_we = dp_cmd.capture && (in_data.cmd == sddp_pkg::CMD_LOAD_V)
                && (32'(in_data.col_index) < COLS_MAX)
                && (32'(in_data.latent_index) < LATENT_MAX);
  assign u_waddr = UA_W'(32'(in_data.row_index) * LATENT_MAX + 32'(in_data.latent_index));
  assign v_waddr = VA_W'(32'(in_data.col_index) * LATENT_MAX + 32'(in_data.latent_index));
  assign u_raddr = UA_W'(32'(row_q) * LATENT_MAX + 32'(k));
  assign v_raddr = VA_W'(32'(col_q) * LATENT_MAX + 32'(k));

  always_ff @(posedge clk) begin
    if (u_we) begin
      u_mem[u_waddr] <= in_data.element;
    end
    u_q <= u_mem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      v_mem[v_waddr] <= in_data.element;
    end
    v_q <= v_mem[v_raddr];
  end

  // An out-of-range row or column gives an empty sum.
  assign sample_in_range = (32'(row_q) < ROWS_MAX) && (32'(col_q) < COLS_MAX);

  // One element pair per cycle: address, read, multiply, accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      d1      <= 1'b0;
      d2      <= 1'b0;
    end else begin
      d1 <= running;
      d2 <= d1;
      if (dp_cmd.mac_start) begin
        running <= sample_in_range && (lat_eff != '0);
      end else if (running && (k + KW'(1) == k_len)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.mac_start) begin
      k     <= '0;
      k_len <= lat_eff;
      acc   <= '0;
    end else begin
      if (running) begin
        k <= k + KW'(1);
      end
      if (d2) begin
        acc <= acc + 40'(prod);
      end
    end
    if (d1) begin
      prod <= u_q * v_q;
    end
  end

  // Column pointer progress and the saturating sample count.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_column  <= '0;
      sample_count <= '0;
    end else if (dp_cmd.finish_clear) begin
      next_column  <= '0;
      sample_count <= '0;
    end else begin
      if (dp_cmd.emit_ptr) begin
        next_column <= next_column + 6'd1;
      end
      if (dp_cmd.emit_entry && (sample_count < CW'(SAMPLES_MAX))) begin
        sample_count <= sample_count + CW'(1);
      end
    end
  end

  // Result register; it frees up in the same cycle the receiver takes it.
  assign dp_status.slot_free = !out_valid || !out_stall;
  assign dp_status.is_finish = (cmd_q == sddp_pkg::CMD_FINISH);
  assign dp_status.ptr_more  = dp_status.is_finish ? (next_column <= ncol)
                               : ((next_column <= {1'b0, col_q}) && (next_column < ncol));
  assign dp_status.dot_done  = !running && !d1 && !d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.emit_ptr || dp_cmd.emit_entry) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit_ptr) begin
      out_data.kind          <= sddp_pkg::KIND_POINTER;
      out_data.dot_value     <= '0;
      out_data.row_out       <= '0;
      out_data.pointer_index <= next_column;
      out_data.pointer_value <= 13'(sample_count);
      out_data.last          <= dp_status.is_finish && (next_column == ncol);
    end else if (dp_cmd.emit_entry) begin
      out_data.kind          <= sddp_pkg::KIND_ENTRY;
      out_data.dot_value     <= acc;
      out_data.row_out       <= row_q;
      out_data.pointer_index <= '0;
      out_data.pointer_value <= '0;
      out_data.last          <= 1'b1;
    end
  end

endmodule

>>> design/sampled_dense_dot_products_csc.sv
// Top level of the sampled dense dot products block with compressed-column
// output. Depends on sddp_pkg, sddp_ctrl, sddp_dp and the assertion macros.
//
// Requests arrive on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; a transfer happens when valid is high and
// stall is low. Load requests write one element of U or V and give no result;
// they are written as they are taken. A sample request first sends the column
// pointers it owes, one per cycle while the receiver does not stall, then runs
// latent_dim element pairs through a single multiply-accumulate, one pair per
// cycle, and sends the entry with last set. A finish request sends the
// remaining pointers through num_columns, the final one with last set, and
// starts a new matrix. One request is worked on at a time; in_stall is high
// until it is done. A finished result sits in the output register while the
// next request is taken; when the receiver stalls, the block waits before its
// next result. Reset clears the counters and loads latent_dim = 64,
// num_columns = 32; the memories are not cleared and must be loaded before
// they are sampled. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while idle, as the block does not enforce it.
module sampled_dense_dot_products_csc #(
  parameter int LATENT_MAX  = sddp_pkg::LATENT_MAX_DEFAULT,
  parameter int ROWS_MAX    = sddp_pkg::ROWS_MAX_DEFAULT,
  parameter int COLS_MAX    = sddp_pkg::COLS_MAX_DEFAULT,
  parameter int SAMPLES_MAX = sddp_pkg::SAMPLES_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sddp_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sddp_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [sddp_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "sampled_dense_dot_products_csc_macros.svh"

  sddp_pkg::dp_cmd_t    dp_cmd;
  sddp_pkg::dp_status_t dp_status;

  sddp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  sddp_dp #(
    .LATENT_MAX  (LATENT_MAX),
    .ROWS_MAX    (ROWS_MAX),
    .COLS_MAX    (COLS_MAX),
    .SAMPLES_MAX (SAMPLES_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `SDDP_ASSERT(a_one_cmd, $onehot0({dp_cmd.capture, dp_cmd.emit_ptr, dp_cmd.mac_start, dp_cmd.emit_entry, dp_cmd.finish_clear}))
  `SDDP_ASSERT_IMPL(a_emit_free, dp_cmd.emit_ptr || dp_cmd.emit_entry, dp_status.slot_free)
  `SDDP_ASSERT_NEXT(a_sample_busy, in_valid && !in_stall && (in_data.cmd == sddp_pkg::CMD_SAMPLE), in_stall)
  `SDDP_ASSERT_NEXT(a_emit_shows, dp_cmd.emit_ptr || dp_cmd.emit_entry, out_valid)

endmodule

>>> sim/tb_sampled_dense_dot_products_csc.sv
// Self-checking testbench for the sampled dense dot products block with CSC output.
// It predicts every pointer and entry result and checks each one against the block.
// Depends on sddp_pkg and the sampled_dense_dot_products_csc top level.
module tb_sampled_dense_dot_products_csc;
  import sddp_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_LATENT_DIM;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sampled_dense_dot_products_csc dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and the CSC results that the accepted ones owe.
  in_t request_queue[$];
  out_t csc_results_due[$];

  // Predicted state of the block.
  logic signed [15:0] u_elems [0:4095];
  logic signed [15:0] v_elems [0:2047];
  int col_cursor = 0;
  int entry_count = 0;
  logic [6:0] dim_reg = LATENT_DIM_RESET;
  logic [5:0] cols_reg = NUM_COLUMNS_RESET;

  // Generator bookkeeping: which store entries have had a load queued so far.
  bit u_loaded [0:4095];
  bit v_loaded [0:2047];
  int gen_col = 0;

  bit calm = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  out_t due_head;

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  function automatic string show(input out_t r);
    return $sformatf("kind=%0d dot=%0d row=%0d pidx=%0d pval=%0d last=%0d",
                     r.kind, r.dot_value, r.row_out, r.pointer_index,
                     r.pointer_value, r.last);
  endfunction

  task automatic push_pointer();
    out_t r;
    r = '0;
    r.kind = KIND_POINTER;
    r.pointer_index = col_cursor[5:0];
    r.pointer_value = entry_count[12:0];
    csc_results_due.push_back(r);
    col_cursor++;
  endtask

  task automatic predict_csc_results(input in_t req);
    int ncol;
    int n;
    int first;
    longint sum;
    out_t r;
    first = csc_results_due.size();
    ncol = (cols_reg > COLS_MAX_DEFAULT) ? COLS_MAX_DEFAULT : cols_reg;
    n = (dim_reg > LATENT_MAX_DEFAULT) ? LATENT_MAX_DEFAULT : dim_reg;
    case (req.cmd)
      CMD_LOAD_U: u_elems[{req.row_index, req.latent_index}] = req.element;
      CMD_LOAD_V: v_elems[{req.col_index, req.latent_index}] = req.element;
      CMD_SAMPLE: begin
        while (col_cursor <= req.col_index && col_cursor < ncol) push_pointer();
        sum = 0;
        for (int k = 0; k < n; k++) begin
          sum += longint'(u_elems[{req.row_index, k[5:0]}]) *
                 longint'(v_elems[{req.col_index, k[5:0]}]);
        end
        r = '0;
        r.kind = KIND_ENTRY;
        r.dot_value = sum[39:0];
        r.row_out = req.row_index;
        csc_results_due.push_back(r);
        if (entry_count < SAMPLES_MAX_DEFAULT) entry_count++;
      end
      default: begin
        while (col_cursor <= ncol) push_pointer();
        col_cursor = 0;
        entry_count = 0;
      end
    endcase
    if (csc_results_due.size() > first) begin
      r = csc_results_due.pop_back();
      r.last = 1'b1;
      csc_results_due.push_back(r);
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_csc_results(in_data);
      if (!in_valid || !in_stall) begin
        if (request_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 35)) begin
          in_data <= request_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (csc_results_due.size() == 0) begin
          note_failure($sformatf("unexpected result: %s", show(out_data)));
        end else begin
          due_head = csc_results_due.pop_front();
          if (out_data.kind !== due_head.kind || out_data.dot_value !== due_head.dot_value ||
              out_data.row_out !== due_head.row_out ||
              out_data.pointer_index !== due_head.pointer_index ||
              out_data.pointer_value !== due_head.pointer_value ||
              out_data.last !== due_head.last) begin
            note_failure($sformatf("expected %s, got %s", show(due_head), show(out_data)));
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 35);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sampled_dense_dot_products_csc: mismatch");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_t make_req(input logic [1:0] cmd, input int row, input int col,
                                   input int lat, input logic signed [15:0] elem);
    in_t q;
    q.cmd = cmd;
    q.row_index = row[5:0];
    q.col_index = col[4:0];
    q.latent_index = lat[5:0];
    q.element = elem;
    return q;
  endfunction

  task automatic push_load(input logic [1:0] cmd, input int row, input int col,
                           input int lat, input logic signed [15:0] elem);
    if (cmd == CMD_LOAD_U) begin
      u_loaded[{row[5:0], lat[5:0]}] = 1'b1;
      col = $urandom_range(0, 31);
    end else begin
      v_loaded[{col[4:0], lat[5:0]}] = 1'b1;
      row = $urandom_range(0, 63);
    end
    request_queue.push_back(make_req(cmd, row, col, lat, elem));
  endtask

  // Queues loads for unwritten parts of the two vectors a sample reads, then the sample.
  task automatic push_sample(input int row, input int col);
    int n;
    n = (dim_reg > LATENT_MAX_DEFAULT) ? LATENT_MAX_DEFAULT : dim_reg;
    for (int k = 0; k < n; k++) begin
      if (!u_loaded[{row[5:0], k[5:0]}]) push_load(CMD_LOAD_U, row, 0, k, rand_elem());
      if (!v_loaded[{col[4:0], k[5:0]}]) push_load(CMD_LOAD_V, 0, col, k, rand_elem());
    end
    request_queue.push_back(make_req(CMD_SAMPLE, row, col, $urandom_range(0, 63),
                                     rand_elem()));
  endtask

  task automatic push_finish();
    request_queue.push_back(make_req(CMD_FINISH, $urandom_range(0, 63),
                                     $urandom_range(0, 31), $urandom_range(0, 63),
                                     rand_elem()));
    gen_col = 0;
  endtask

  // Waits until every request is taken and every result is back, then lets the
  // block finish any request that gives no result.
  task automatic settle();
    while (request_queue.size() != 0 || in_valid || csc_results_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input int dim, input int cols);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LATENT_DIM;
    cfg_data <= dim[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_NUM_COLUMNS;
    cfg_data <= cols[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_reg = dim[6:0];
    cols_reg = cols[5:0];
  endtask

  // Mostly well-formed matrices: loads, samples in rising column order, a finish.
  task automatic random_phase(input int count);
    int pick;
    int col;
    int step;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        if ($urandom_range(0, 1) == 0)
          push_load(CMD_LOAD_U, $urandom_range(0, 63), 0, $urandom_range(0, 63), rand_elem());
        else
          push_load(CMD_LOAD_V, 0, $urandom_range(0, 31), $urandom_range(0, 63), rand_elem());
      end else if (pick < 88) begin
        if ($urandom_range(0, 9) == 0) begin
          col = $urandom_range(0, 31);
        end else begin
          step = $urandom_range(0, 2);
          gen_col = (gen_col + step > 31) ? 31 : gen_col + step;
          col = gen_col;
        end
        push_sample($urandom_range(0, 63), col);
      end else begin
        push_finish();
      end
    end
    push_finish();
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full-length sums with extreme elements, the longest finish run,
    // and a finish over an empty matrix.
    push_load(CMD_LOAD_U, 0, 0, 0, 16'sh7fff);
    push_load(CMD_LOAD_V, 0, 0, 0, 16'sh7fff);
    push_load(CMD_LOAD_U, 0, 0, 63, 16'sh8000);
    push_load(CMD_LOAD_V, 0, 0, 63, 16'sh8000);
    push_sample(0, 0);
    push_sample(0, 0);
    push_finish();
    push_finish();
    settle();

    // Short sums: the longest pointer run ahead of a sample, then an unsorted column.
    set_registers(1, 32);
    push_sample(1, 31);
    push_sample(2, 5);
    push_finish();
    settle();

    // Columns at or beyond num_columns, then a finish that has nothing left to send.
    set_registers(1, 4);
    push_sample(2, 10);
    push_sample(2, 31);
    push_finish();
    push_sample(3, 2);
    settle();
    set_registers(1, 1);
    push_finish();
    settle();

    // Zero latent dimension and zero columns.
    set_registers(0, 0);
    push_sample(7, 7);
    push_finish();
    settle();

    // Register values above the parameters are clamped.
    set_registers(127, 63);
    push_sample(0, 0);
    push_finish();
    settle();

    set_registers(2, 7);
    calm = 1'b1;
    random_phase(14);
    calm = 1'b0;
    set_registers(3, 32);
    random_phase(10);
    set_registers(1, 20);
    random_phase(14);

    if (csc_results_due.size() != 0) note_failure("results still outstanding at the end");
    if (error_count == 0) begin
      $display("sampled_dense_dot_products_csc: match");
    end else begin
      $display("sampled_dense_dot_products_csc: mismatch");
    end
    $finish;
  end

endmodule

>>> sampled_dense_dot_products_csc.f
+incdir+design
design/sddp_pkg.sv
design/sddp_ctrl.sv
design/sddp_dp.sv
design/sampled_dense_dot_products_csc.sv
sim/tb_sampled_dense_dot_products_csc.sv
